FILE: src/ccmp_pkg.sv
// Package for the clipped mask compositor: command, blend mode and register
// codes, field widths and default sizes. No dependencies.
package ccmp_pkg;

    localparam int LEVEL_W     = 5;
    localparam int LEVEL_MAX   = 31;
    localparam int TINT_W      = 12;
    localparam int WORD_W      = 16;
    localparam int LEVEL_SHIFT = 12;
    localparam int COORD_W     = 8;
    localparam int SIZE_W      = 9;
    localparam int OFFS_W      = 10;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_BLEND = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_COPY = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_SUB  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_WIDTH  = 3'd0,
        REG_DEST_HEIGHT = 3'd1,
        REG_OFFSET_X    = 3'd2,
        REG_OFFSET_Y    = 3'd3,
        REG_BLEND_MODE  = 3'd4,
        REG_TINT_COLOR  = 3'd5
    } t_reg_idx;

    // Placement settings handed from the register bank to the target unit.
    typedef struct packed {
        logic [SIZE_W-1:0]        dest_width;
        logic [SIZE_W-1:0]        dest_height;
        logic signed [OFFS_W-1:0] offset_x;
        logic signed [OFFS_W-1:0] offset_y;
    } t_place_cfg;

endpackage

FILE: src/clipped_mask_compositor.sv
// Top level of the clipped mask compositor: register bank, command pipeline,
// blend arithmetic and output register. Depends on ccmp_pkg, ccmp_target and
// ccmp_store.
//
//  Channel      | Direction | Handshake                 | Contents
//  -------------+-----------+---------------------------+-------------------------------
//  s_axis       | in        | tvalid / tready           | tdata: col, row, src_level,
//               |           |                           | surface_word; tuser: cmd
//  m_axis       | out       | tvalid / tready           | tdata: level_out, packed_word;
//               |           |                           | tuser: clipped
//  cfg          | in        | write enable, no wait     | register index, write data
//
// One command is taken per cycle for as long as results are taken; each gives one
// result transfer, after passing the memory stage and the output register. The rate
// is set by the single read port and single write port of the mask memory: the read
// is issued on acceptance and the updated level is written back as the command leaves
// the memory stage, with the written value forwarded to a read of the same entry on that edge.
// Reset (i_rst_n low at a clock edge) empties the pipeline and restores the
// register defaults, and the input ready stays low while reset is held; the
// mask contents are not cleared and read as undefined until written. When the
// result side stalls, the pipeline holds and the input side deasserts its
// ready once the pipeline stage is full.
module clipped_mask_compositor #(
    parameter int MAX_WIDTH  = ccmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ccmp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input transfers.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: col [7:0], row [15:8], src_level [20:16], surface_word [36:21], zero [39:37]
    input  logic [39:0]                       i_s_axis_tdata,
    // tuser: cmd [1:0]
    input  logic [1:0]                        i_s_axis_tuser,
    // Result transfers.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: level_out [4:0], packed_word [20:5], zero [23:21]
    output logic [23:0]                       o_m_axis_tdata,
    // tuser: clipped [0]
    output logic [0:0]                        o_m_axis_tuser,
    // Configuration writes.
    input  logic                              i_cfg_we,
    input  logic [ccmp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ccmp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ccmp_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW_RAW = $clog2(DEPTH);
    localparam int AW     = (AW_RAW < 1) ? 1 : AW_RAW;

    // Configuration registers.
    logic [SIZE_W-1:0]        r_dest_w;
    logic [SIZE_W-1:0]        r_dest_h;
    logic signed [OFFS_W-1:0] r_off_x;
    logic signed [OFFS_W-1:0] r_off_y;
    logic [1:0]               r_mode;
    logic [TINT_W-1:0]        r_tint;
    t_place_cfg               place_cfg;

    // Input fields.
    t_cmd                in_cmd;
    logic [COORD_W-1:0]  in_col;
    logic [COORD_W-1:0]  in_row;
    logic [LEVEL_W-1:0]  in_src;
    logic [WORD_W-1:0]   in_word;
    logic                in_accept;
    logic                in_clip;
    logic [AW-1:0]       in_addr;

    // Memory stage: the read data for this command arrives here.
    logic                r_s1_valid;
    t_cmd                r_s1_cmd;
    logic                r_s1_clip;
    logic [AW-1:0]       r_s1_addr;
    logic [LEVEL_W-1:0]  r_s1_src;
    logic [LEVEL_W-1:0]  r_s1_load;
    logic                s1_adv;
    logic [LEVEL_W-1:0]  dest_level;
    logic [LEVEL_W-1:0]  n_level;
    logic [LEVEL_W:0]    sum;
    logic                wr_en;

    // Output register.
    logic                r_out_valid;
    logic [LEVEL_W-1:0]  r_out_level;
    logic [WORD_W-1:0]   r_out_word;
    logic                r_out_clip;
    logic [WORD_W-1:0]   n_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w <= SIZE_W'(256);
            r_dest_h <= SIZE_W'(256);
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_mode   <= MODE_COPY;
            r_tint   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_DEST_WIDTH:  r_dest_w <= i_cfg_data[SIZE_W-1:0];
                REG_DEST_HEIGHT: r_dest_h <= i_cfg_data[SIZE_W-1:0];
                REG_OFFSET_X:    r_off_x  <= $signed(i_cfg_data[OFFS_W-1:0]);
                REG_OFFSET_Y:    r_off_y  <= $signed(i_cfg_data[OFFS_W-1:0]);
                REG_BLEND_MODE:  r_mode   <= i_cfg_data[1:0];
                REG_TINT_COLOR:  r_tint   <= i_cfg_data[TINT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        place_cfg.dest_width  = r_dest_w;
        place_cfg.dest_height = r_dest_h;
        place_cfg.offset_x    = r_off_x;
        place_cfg.offset_y    = r_off_y;
    end

    assign in_cmd  = t_cmd'(i_s_axis_tuser);
    assign in_col  = i_s_axis_tdata[7:0];
    assign in_row  = i_s_axis_tdata[15:8];
    assign in_src  = i_s_axis_tdata[20:16];
    assign in_word = i_s_axis_tdata[36:21];

    // The memory stage moves on whenever the output register is free or being
    // emptied; a new command enters only when the memory stage can take it.
    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    ccmp_target #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_target (
        .i_cmd  (in_cmd),
        .i_col  (in_col),
        .i_row  (in_row),
        .i_cfg  (place_cfg),
        .o_clip (in_clip),
        .o_addr (in_addr)
    );

    // Unclipped loads and blends write back exactly once, on the edge the command
    // leaves the memory stage, so a following read sees it via the bypass.
    assign wr_en = s1_adv && !r_s1_clip &&
                   ((r_s1_cmd == CMD_LOAD) || (r_s1_cmd == CMD_BLEND));

    ccmp_store #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (in_accept),
        .i_rd_addr  (in_addr),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_s1_addr),
        .i_wr_data  (n_level),
        .o_rd_level (dest_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd  <= in_cmd;
            r_s1_clip <= in_clip;
            r_s1_addr <= in_addr;
            r_s1_src  <= in_src;
            r_s1_load <= in_word[LEVEL_W-1:0];
        end
    end

    // Blend arithmetic. A blend mode code of three behaves as a copy.
    always_comb begin
        sum = {1'b0, dest_level} + {1'b0, r_s1_src};
        unique case (r_s1_cmd)
            CMD_LOAD: n_level = r_s1_load;
            CMD_BLEND: begin
                unique case (t_mode'(r_mode))
                    MODE_ADD: n_level = sum[LEVEL_W] ? LEVEL_W'(LEVEL_MAX)
                                                     : sum[LEVEL_W-1:0];
                    MODE_SUB: n_level = (dest_level > r_s1_src) ? dest_level - r_s1_src
                                                                : '0;
                    default:  n_level = r_s1_src;
                endcase
            end
            CMD_READ: n_level = dest_level;
            CMD_NOP:  n_level = '0;
        endcase

        // A clipped target or an empty command reports zero level and word.
        if (r_s1_clip || (r_s1_cmd == CMD_NOP)) begin
            n_word = '0;
        end else begin
            n_word = {n_level[3:0], r_tint};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_level <= r_s1_clip ? '0 : n_level;
            r_out_word  <= n_word;
            r_out_clip  <= r_s1_clip;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_word, r_out_level};
    assign o_m_axis_tuser  = r_out_clip;

    // A command held in the memory stage keeps its target.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_addr) && $stable(r_s1_cmd))
        else $error("memory stage lost or changed a held command");

    // A read issued on the edge that writes the same entry returns the new level.
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en && in_accept && (r_s1_addr == in_addr) |=> dest_level == $past(n_level))
        else $error("write-back not forwarded to a read of the same entry");

    // Clipped results carry no level and no packed word.
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("clipped result carries data");

    // A clipped command leaving the memory stage becomes a clipped result.
    a_no_clip_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1_clip |=> o_m_axis_tuser[0] && o_m_axis_tvalid)
        else $error("clipped command did not produce a clipped result");

endmodule

FILE: src/ccmp_target.sv
// Target unit of the clipped mask compositor: resolves the destination pixel
// of a command, clips it against the size in use and forms the mask address.
// Depends on ccmp_pkg.
module ccmp_target #(
    parameter int MAX_WIDTH  = ccmp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ccmp_pkg::DEF_MAX_HEIGHT,
    parameter int AW         = 16
) (
    input  ccmp_pkg::t_cmd                  i_cmd,
    input  logic [ccmp_pkg::COORD_W-1:0]    i_col,
    input  logic [ccmp_pkg::COORD_W-1:0]    i_row,
    input  ccmp_pkg::t_place_cfg            i_cfg,
    output logic                            o_clip,
    output logic [AW-1:0]                   o_addr
);
    import ccmp_pkg::*;

    localparam int WCAP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int HCAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
    localparam int PW   = AW + SIZE_W + 1;

    logic [SIZE_W-1:0]   eff_w;
    logic [SIZE_W-1:0]   eff_h;
    logic signed [10:0]  x;
    logic signed [10:0]  y;
    logic                in_dest;
    logic [PW-1:0]       lin;

    always_comb begin
        eff_w = (i_cfg.dest_width  < SIZE_W'(WCAP)) ? i_cfg.dest_width  : SIZE_W'(WCAP);
        eff_h = (i_cfg.dest_height < SIZE_W'(HCAP)) ? i_cfg.dest_height : SIZE_W'(HCAP);

        // Blends are placed by the signed offset; loads and reads address directly.
        if (i_cmd == CMD_BLEND) begin
            x = $signed({3'b000, i_col}) + {i_cfg.offset_x[OFFS_W-1], i_cfg.offset_x};
            y = $signed({3'b000, i_row}) + {i_cfg.offset_y[OFFS_W-1], i_cfg.offset_y};
        end else begin
            x = $signed({3'b000, i_col});
            y = $signed({3'b000, i_row});
        end

        in_dest = (x >= 0) && (y >= 0) &&
                  (x < $signed({2'b00, eff_w})) && (y < $signed({2'b00, eff_h}));
        o_clip  = (i_cmd != CMD_NOP) && !in_dest;

        // Rows are MAX_WIDTH entries apart; the product is by a constant.
        lin    = PW'(y[SIZE_W-1:0]) * PW'(MAX_WIDTH) + PW'(x[SIZE_W-1:0]);
        o_addr = lin[AW-1:0];
    end

endmodule

FILE: src/ccmp_store.sv
// Mask store of the clipped mask compositor: one synchronous memory with a
// registered read and a bypass for a write to the address being read.
// Depends on ccmp_pkg.
module ccmp_store #(
    parameter int AW    = 16,
    parameter int DEPTH = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rd_en,
    input  logic [AW-1:0]                  i_rd_addr,
    input  logic                           i_wr_en,
    input  logic [AW-1:0]                  i_wr_addr,
    input  logic [ccmp_pkg::LEVEL_W-1:0]   i_wr_data,
    output logic [ccmp_pkg::LEVEL_W-1:0]   o_rd_level
);
    import ccmp_pkg::*;

    logic [LEVEL_W-1:0] mem [DEPTH];
    logic [LEVEL_W-1:0] r_rd_data;
    logic               r_byp;
    logic [LEVEL_W-1:0] r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read issued on the edge that writes the same entry would see the old
    // contents, so the written level is captured alongside it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_level = r_byp ? r_byp_data : r_rd_data;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for clipped_mask_compositor: directed and random command
// streams with random idling on both stream sides. Depends on ccmp_pkg and the RTL.

module tb;
    import ccmp_pkg::*;

    localparam int MAXW        = DEF_MAX_WIDTH;
    localparam int MAXH        = DEF_MAX_HEIGHT;
    localparam int IDLE_PCT    = 34;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 4;

    // Blend mode 3 has no name in the package; the block treats it as a copy.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // One command as it travels on the input stream.
    typedef struct {
        t_cmd       cmd;
        logic [7:0] col;
        logic [7:0] row;
        logic [4:0] src;
        logic [15:0] word;
    } pix_cmd_t;

    // One result as it travels on the output stream.
    typedef struct {
        logic [4:0]  level;
        logic [15:0] tinted;
        logic        clipped;
    } pix_res_t;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [39:0] s_data  = '0;
    logic [1:0]  s_user  = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;
    logic [0:0]  m_user;
    logic        cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    clipped_mask_compositor #(
        .MAX_WIDTH  (MAXW),
        .MAX_HEIGHT (MAXH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // tdata: col [7:0], row [15:8], src_level [20:16], surface_word [36:21], zero [39:37]
        .i_s_axis_tdata  (s_data),
        // tuser: cmd [1:0]
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // tdata: level_out [4:0], packed_word [20:5], zero [23:21]
        .o_m_axis_tdata  (m_data),
        // tuser: clipped [0]
        .o_m_axis_tuser  (m_user),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // Shadow of the destination mask and the register bank. The written map tells
    // which entries hold a defined level; reads and blends only ever land on those.
    logic [4:0]  mask_shadow [MAXW*MAXH];
    bit          written_map [MAXW*MAXH];
    int          written_cells [$];
    int          recent_cells [$];
    int unsigned dim_w   = 256;
    int unsigned dim_h   = 256;
    int          off_x   = 0;
    int          off_y   = 0;
    logic [1:0]  mode_sh = MODE_COPY;
    logic [11:0] tint_sh = '0;

    // Results still owed by the block, oldest first.
    pix_res_t    pending_px [$];

    // When set, the matching side never idles.
    bit steady_tx = 1'b0;
    bit steady_rx = 1'b0;

    int     n_errors  = 0;
    int     n_checked = 0;
    int     n_clipped = 0;
    int     n_load    = 0;
    int     n_blend   = 0;
    int     n_read    = 0;
    int     n_nop     = 0;
    longint cycle_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed.",
                     cycle_cnt, pending_px.size());
            $display("FAILURE");
            $finish;
        end
    end

    // The result side stalls at random unless a steady stretch is running.
    always @(posedge i_clk) begin
        m_ready <= steady_rx || ($urandom_range(99) >= IDLE_PCT);
    end

    // Works out where a command lands in the mask. in_bounds is low for clipped
    // targets and for the no-op command, which touches nothing.
    function automatic int locate(pix_cmd_t c, output bit in_bounds);
        int x, y, ew, eh;
        x  = int'(c.col);
        y  = int'(c.row);
        ew = (dim_w < MAXW) ? int'(dim_w) : MAXW;
        eh = (dim_h < MAXH) ? int'(dim_h) : MAXH;
        if (c.cmd == CMD_BLEND) begin
            x += off_x;
            y += off_y;
        end
        in_bounds = (c.cmd != CMD_NOP) && x >= 0 && y >= 0 && x < ew && y < eh;
        return y * MAXW + x;
    endfunction

    // Applies one command to the shadow mask and returns the result it causes.
    function automatic pix_res_t composite(pix_cmd_t c);
        pix_res_t   r;
        bit         hit;
        int         k;
        logic [4:0] d;
        logic [4:0] lvl;
        logic [5:0] sum;
        r = '{level: '0, tinted: '0, clipped: 1'b0};
        k = locate(c, hit);
        if (c.cmd == CMD_NOP)
            return r;
        if (!hit) begin
            r.clipped = 1'b1;
            return r;
        end
        d = mask_shadow[k];
        case (c.cmd)
            CMD_LOAD: begin
                lvl = c.word[4:0];
            end
            CMD_BLEND: begin
                if (mode_sh == MODE_ADD) begin
                    sum = {1'b0, d} + {1'b0, c.src};
                    lvl = (sum > LEVEL_MAX) ? 5'(LEVEL_MAX) : sum[4:0];
                end else if (mode_sh == MODE_SUB) begin
                    lvl = (d > c.src) ? d - c.src : 5'd0;
                end else begin
                    // Copy, and the unnamed fourth mode behaves the same way.
                    lvl = c.src;
                end
            end
            default: begin
                lvl = d;
            end
        endcase
        if (c.cmd != CMD_READ) begin
            mask_shadow[k] = lvl;
            if (!written_map[k]) begin
                written_map[k] = 1'b1;
                written_cells.push_back(k);
            end
            // Recently touched entries feed back-to-back hazards on the same pixel.
            recent_cells.push_back(k);
            if (recent_cells.size() > 8)
                void'(recent_cells.pop_front());
        end
        r.level  = lvl;
        r.tinted = {lvl[3:0], tint_sh};
        return r;
    endfunction

    // Draws a random command. Reads and blends mostly aim at entries already
    // written, often the most recent ones; a draw that would touch an undefined
    // entry is thrown away and redrawn, and the last of sixteen draws becomes a load.
    function automatic pix_cmd_t random_pixel();
        pix_cmd_t c;
        bit       hit;
        int       k, pick, x, y, ew, eh;
        ew = (dim_w < MAXW) ? int'(dim_w) : MAXW;
        eh = (dim_h < MAXH) ? int'(dim_h) : MAXH;
        for (int tries = 0; tries < 16; tries++) begin
            c.src  = 5'($urandom);
            c.word = 16'($urandom);
            c.col  = 8'($urandom);
            c.row  = 8'($urandom);
            pick   = $urandom_range(99);
            c.cmd  = (pick < 30) ? CMD_LOAD : (pick < 63) ? CMD_BLEND :
                     (pick < 96) ? CMD_READ : CMD_NOP;
            if (c.cmd == CMD_LOAD && ew > 0 && eh > 0 && $urandom_range(1) == 1) begin
                c.col = 8'($urandom_range(ew - 1));
                c.row = 8'($urandom_range(eh - 1));
            end
            if (c.cmd != CMD_NOP && recent_cells.size() != 0 && $urandom_range(9) < 8 &&
                (c.cmd != CMD_LOAD || $urandom_range(2) == 0)) begin
                if ($urandom_range(2) == 0)
                    k = written_cells[$urandom_range(written_cells.size() - 1)];
                else
                    k = recent_cells[$urandom_range(recent_cells.size() - 1)];
                x = k % MAXW;
                y = k / MAXW;
                if (c.cmd == CMD_BLEND) begin
                    x -= off_x;
                    y -= off_y;
                end
                if (x >= 0 && x <= 255 && y >= 0 && y <= 255) begin
                    c.col = 8'(x);
                    c.row = 8'(y);
                end
            end
            k = locate(c, hit);
            if (!hit || c.cmd == CMD_LOAD || written_map[k])
                return c;
        end
        c.cmd = CMD_LOAD;
        return c;
    endfunction

    // Sends one command, idling first now and then, and records the result it
    // owes once the input transfer has happened.
    task automatic send_pixel(pix_cmd_t c);
        if (!steady_tx && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {3'b000, c.word, c.src, c.row, c.col};
        s_user  <= c.cmd;
        do @(posedge i_clk); while (s_ready !== 1'b1);
        pending_px.push_back(composite(c));
        case (c.cmd)
            CMD_LOAD:  n_load++;
            CMD_BLEND: n_blend++;
            CMD_READ:  n_read++;
            default:   n_nop++;
        endcase
    endtask

    task automatic send_fields(t_cmd cmd, int col, int row, int src, int word);
        pix_cmd_t c;
        c.cmd  = cmd;
        c.col  = 8'(col);
        c.row  = 8'(row);
        c.src  = 5'(src);
        c.word = 16'(word);
        send_pixel(c);
    endtask

    // Stops sending and waits until every owed result has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_px.size() != 0) @(posedge i_clk);
    endtask

    // Writes all six registers while the block is idle and mirrors them.
    task automatic apply_config(int unsigned w, int unsigned h, int ox, int oy,
                                logic [1:0] mode, logic [11:0] tint);
        t_reg_idx    regs [6];
        logic [11:0] vals [6];
        logic signed [9:0] sx, sy;
        regs = '{REG_DEST_WIDTH, REG_DEST_HEIGHT, REG_OFFSET_X, REG_OFFSET_Y,
                 REG_BLEND_MODE, REG_TINT_COLOR};
        sx   = 10'(ox);
        sy   = 10'(oy);
        vals = '{12'(w[8:0]), 12'(h[8:0]), {2'b00, sx}, {2'b00, sy},
                 {10'b0, mode}, tint};
        wait_idle();
        for (int i = 0; i < 6; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= regs[i];
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we  <= 1'b0;
        dim_w   = w[8:0];
        dim_h   = h[8:0];
        off_x   = int'(sx);
        off_y   = int'(sy);
        mode_sh = mode;
        tint_sh = tint;
    endtask

    function automatic int unsigned pick_size();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return $urandom_range(1, 32);
            5, 6:          return $urandom_range(1, 511);
            7:             return 511;
            default:       return 256;
        endcase
    endfunction

    function automatic int pick_offset();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return int'($urandom_range(16)) - 8;
            6:                return -256;
            7:                return 256;
            default:          return int'($urandom_range(1023)) - 512;
        endcase
    endfunction

    // Result checker: every output transfer is compared with the oldest result
    // still owed. A failure is counted and the run carries on.
    always @(posedge i_clk) begin
        pix_res_t want;
        if (i_rst_n && m_valid === 1'b1 && m_ready) begin
            n_checked++;
            if (m_user[0] === 1'b1)
                n_clipped++;
            if (pending_px.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, got data %h user %b",
                         $time, m_data, m_user);
            end else begin
                want = pending_px.pop_front();
                if (m_data[4:0] !== want.level) begin
                    n_errors++;
                    $display("%0t: level_out mismatch, expected %0d, got %0d",
                             $time, want.level, m_data[4:0]);
                end
                if (m_data[20:5] !== want.tinted) begin
                    n_errors++;
                    $display("%0t: packed_word mismatch, expected %h, got %h",
                             $time, want.tinted, m_data[20:5]);
                end
                if (m_user[0] !== want.clipped) begin
                    n_errors++;
                    $display("%0t: clipped mismatch, expected %b, got %b",
                             $time, want.clipped, m_user[0]);
                end
            end
        end
    end

    // Corner pixels of the full mask, top surface bits that must be dropped, a
    // plain copy blend and a no-op command with every bit set.
    task automatic test_extremes();
        apply_config(256, 256, 0, 0, MODE_COPY, 12'h000);
        send_fields(CMD_LOAD, 0, 0, 0, 16'hFFFF);
        send_fields(CMD_LOAD, 255, 255, 31, 16'hFFE0);
        send_fields(CMD_LOAD, 255, 0, 0, 16'h0015);
        send_fields(CMD_LOAD, 0, 255, 0, 16'hAAAA);
        send_fields(CMD_READ, 0, 0, 31, 16'hFFFF);
        send_fields(CMD_READ, 255, 255, 0, 16'h0000);
        send_fields(CMD_READ, 255, 0, 0, 16'h0000);
        send_fields(CMD_BLEND, 255, 255, 31, 16'h0000);
        send_fields(CMD_READ, 255, 255, 0, 16'h0000);
        send_fields(CMD_NOP, 255, 255, 31, 16'hFFFF);
    endtask

    // Saturating add at the top, floored subtract at the bottom, and the
    // unnamed mode that falls back to copy; the tint shows in packed words.
    task automatic test_blend_modes();
        apply_config(256, 256, 0, 0, MODE_ADD, 12'hFFF);
        send_fields(CMD_BLEND, 0, 0, 31, 16'h0000);
        send_fields(CMD_BLEND, 255, 0, 1, 16'h0000);
        apply_config(256, 256, 0, 0, MODE_SUB, 12'hA5C);
        send_fields(CMD_BLEND, 255, 255, 5, 16'h0000);
        send_fields(CMD_BLEND, 255, 255, 31, 16'h0000);
        apply_config(256, 256, 0, 0, MODE_SPARE, 12'h5A3);
        send_fields(CMD_BLEND, 0, 0, 7, 16'h0000);
        send_fields(CMD_READ, 0, 0, 0, 16'h0000);
    endtask

    // A one-pixel mask, a zero-size mask, sizes beyond the memory, and offsets up to
    // the bottom of their range that push the target off the left, right and top edges.
    task automatic test_clipping();
        apply_config(1, 1, 0, 0, MODE_COPY, 12'h123);
        send_fields(CMD_LOAD, 0, 0, 0, 16'h0009);
        send_fields(CMD_LOAD, 1, 0, 0, 16'h0003);
        send_fields(CMD_READ, 0, 1, 0, 16'h0000);
        apply_config(0, 256, 0, 0, MODE_COPY, 12'h123);
        send_fields(CMD_LOAD, 0, 0, 0, 16'h0004);
        apply_config(511, 511, 256, -512, MODE_ADD, 12'hFFF);
        send_fields(CMD_BLEND, 0, 255, 3, 16'h0000);
        apply_config(511, 511, -1, -1, MODE_ADD, 12'h000);
        send_fields(CMD_BLEND, 1, 1, 4, 16'h0000);
        send_fields(CMD_BLEND, 0, 0, 4, 16'h0000);
    endtask

    // Random commands under a series of random settings. One phase stops in
    // the middle until every owed result is back before it goes on.
    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            apply_config(pick_size(), pick_size(), pick_offset(), pick_offset(),
                         2'($urandom_range(3)), 12'($urandom));
            for (int n = 0; n < 120; n++) begin
                if (ph == 2 && n == 60)
                    wait_idle();
                send_pixel(random_pixel());
            end
        end
    endtask

    // A long stretch with neither side idling, on a small mask so that the
    // same pixels are loaded, blended and read back to back.
    task automatic test_steady_stream();
        apply_config(16, 16, 2, -3, MODE_ADD, 12'($urandom));
        steady_tx = 1'b1;
        steady_rx = 1'b1;
        for (int n = 0; n < 130; n++)
            send_pixel(random_pixel());
        wait_idle();
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_blend_modes();
        test_clipping();
        test_random_phases();
        test_steady_stream();

        // Let any stray result surface before judging the run.
        wait_idle();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d loads, %0d blends, %0d reads and %0d no-op commands.",
                 n_load, n_blend, n_read, n_nop);
        $display("Checked %0d results, %0d of them clipped, with %0d mismatches.",
                 n_checked, n_clipped, n_errors);
        if (n_errors == 0 && pending_px.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
